### hdl/cpe_pkg.sv
// Package: shared constants, codes and controller/datapath interface types.
`timescale 1ns / 1ps
package cpe_pkg;

  localparam int NPOS   = 8;                // positions held
  localparam int NSLOT  = 16;               // digit codes 0..15
  localparam int POS_W  = 3;
  localparam int DIG_W  = 4;
  localparam int CNT_W  = 4;                // holds 0..NPOS
  localparam int LINK_DEPTH = NPOS * NSLOT;

  typedef enum logic [1:0] {
    CMD_FORBID = 2'd0,
    CMD_LINK   = 2'd1,
    CMD_FIRST  = 2'd2,
    CMD_NEXT   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_NPOS  = 2'd0,
    CFG_RANGE = 2'd1,
    CFG_DIAG  = 2'd2,
    CFG_LINKS = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    NF_ARR   = 2'd0,
    NF_ZERO  = 2'd1,
    NF_TRIED = 2'd2
  } nf_src_t;

  typedef struct packed {
    logic    forbid;
    logic    link_wr;
    logic    init_fill;
    logic    init_adv;
    logic    ap_dec;
    logic    load_d;
    nf_src_t nf_src;
    logic    set_start;
    logic    fill_begin;
    logic    place;
    logic    back;
    logic    mark;
    logic    mark_val;
    logic    p_inc;
    logic    walk_apply;
    logic    walk_step;
    logic    out_load;
    logic    out_found;
  } dp_cmd_t;

  typedef struct packed {
    logic started;
    logic links_en;
    logic ap_zero;
    logic d_zero;
    logic d_first_zero;
    logic p_at_n;
    logic p_at_start;
    logic t_zero;
    logic walk_last;
    logic out_free;
    logic emit_last;
  } dp_stat_t;

endpackage

### hdl/cpe_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cpe_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/cpe_datapath.sv
// Datapath: configuration, marks, arrangement, link walk, link RAM and output word register.
`timescale 1ns / 1ps
module cpe_datapath import cpe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [3:0]       cfg_data,
  input  logic [POS_W-1:0] in_position,
  input  logic [DIG_W-1:0] in_digit,
  input  logic [DIG_W-1:0] in_link_target,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_found,
  output logic [POS_W-1:0] out_slot_index,
  output logic [DIG_W-1:0] out_slot_digit,
  output logic             out_last
);

  localparam logic [NSLOT-1:0] AV_INIT = ~NSLOT'(1);

  logic [CNT_W-1:0] npos_r;
  logic [DIG_W-1:0] range_r;
  logic             diag_r, links_r;

  logic [DIG_W-1:0] arr_r   [NPOS];
  logic [DIG_W-1:0] tried_r [NPOS];
  logic [NSLOT-1:0] avail_r [NPOS];
  logic [NSLOT-1:0] forb_r  [NPOS];
  logic [NSLOT-1:0] linkav_r[NPOS];
  logic             started_r;
  logic [CNT_W-1:0] p_r, ap_r;
  logic [POS_W-1:0] start_r, walk_i_r, e_r;
  logic [DIG_W-1:0] d_r, walk_nx_r;
  logic             walk_val_r;

  logic             out_valid_r, out_found_r, out_last_r;
  logic [POS_W-1:0] out_slot_r;
  logic [DIG_W-1:0] out_digit_r;

  logic [CNT_W-1:0] n, n_nxt, npos_nxt;
  logic [DIG_W-1:0] range_nxt;
  logic             diag_nxt, links_nxt;
  logic [DIG_W-1:0] init_arr  [NPOS];
  logic [NSLOT-1:0] init_avail[NPOS];

  logic [POS_W-1:0] p_idx, k;
  logic [DIG_W-1:0] nf_from, nf, d_first, mk_dig;
  logic [DIG_W-1:0] ram_rdata;
  logic             ram_we;
  logic [POS_W+DIG_W-1:0] ram_waddr, ram_raddr;

  function automatic logic [CNT_W-1:0] sat_n(input logic [CNT_W-1:0] v);
    if (v == '0) begin
      return CNT_W'(1);
    end else if (v > CNT_W'(NPOS)) begin
      return CNT_W'(NPOS);
    end
    return v;
  endfunction

  // lowest free digit above 'from', up to the digit range
  function automatic logic [DIG_W-1:0] next_free(input logic [NSLOT-1:0] av,
                                                 input logic [NSLOT-1:0] lk,
                                                 input logic             len,
                                                 input logic [DIG_W-1:0] top,
                                                 input logic [DIG_W-1:0] from);
    logic [NSLOT-1:0] ok;
    logic [DIG_W-1:0] res;
    ok  = av & (len ? lk : '1);
    res = '0;
    for (int d = NSLOT - 1; d >= 1; d--) begin
      if (ok[d] && (DIG_W'(d) > from) && (DIG_W'(d) <= top)) begin
        res = DIG_W'(d);
      end
    end
    return res;
  endfunction

  always_comb begin
    npos_nxt  = (cfg_we && cfg_index == CFG_NPOS)  ? cfg_data : npos_r;
    range_nxt = (cfg_we && cfg_index == CFG_RANGE) ? cfg_data : range_r;
    diag_nxt  = (cfg_we && cfg_index == CFG_DIAG)  ? cfg_data[0] : diag_r;
    links_nxt = (cfg_we && cfg_index == CFG_LINKS) ? cfg_data[0] : links_r;
    n_nxt     = sat_n(npos_nxt);
    for (int j = 0; j < NPOS; j++) begin
      if (diag_nxt && (CNT_W'(j) < n_nxt)) begin
        // digits 1..j+1 are taken at position j
        init_arr[j]   = DIG_W'(j + 1);
        init_avail[j] = AV_INIT
                        & ~(NSLOT'(((NSLOT + 1)'(1) << (j + 2)) - (NSLOT + 1)'(1)));
      end else begin
        init_arr[j]   = '0;
        init_avail[j] = AV_INIT;
      end
    end
  end

  assign n       = sat_n(npos_r);
  assign p_idx   = p_r[POS_W-1:0];
  assign k       = p_idx - start_r;
  assign mk_dig  = arr_r[p_idx];

  always_comb begin
    case (cmd.nf_src)
      NF_ARR:   nf_from = arr_r[p_idx];
      NF_ZERO:  nf_from = '0;
      NF_TRIED: nf_from = tried_r[k];
      default:  nf_from = '0;
    endcase
  end

  assign nf      = next_free(avail_r[p_idx], linkav_r[p_idx], links_r, range_r, nf_from);
  assign d_first = (d_r != '0) ? d_r : nf;

  assign ram_we    = cmd.link_wr;
  assign ram_waddr = {in_position, in_digit - DIG_W'(1)};
  assign ram_raddr = {walk_i_r, walk_nx_r - DIG_W'(1)};

  cpe_ram #(
    .WIDTH (DIG_W),
    .DEPTH (LINK_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_link_target),
    .re    (cmd.walk_apply),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      npos_r    <= CNT_W'(NPOS);
      range_r   <= DIG_W'(8);
      diag_r    <= 1'b0;
      links_r   <= 1'b0;
      started_r <= 1'b0;
      p_r       <= '0;
      ap_r      <= '0;
      start_r   <= '0;
      d_r       <= '0;
      for (int j = 0; j < NPOS; j++) begin
        arr_r[j]    <= '0;
        tried_r[j]  <= '0;
        avail_r[j]  <= AV_INIT;
        forb_r[j]   <= '0;
        linkav_r[j] <= '1;
      end
    end else if (cfg_we) begin
      npos_r    <= npos_nxt;
      range_r   <= range_nxt;
      diag_r    <= diag_nxt;
      links_r   <= links_nxt;
      started_r <= diag_nxt;
      for (int j = 0; j < NPOS; j++) begin
        arr_r[j]    <= init_arr[j];
        tried_r[j]  <= '0;
        avail_r[j]  <= init_avail[j];
        forb_r[j]   <= '0;
        linkav_r[j] <= '1;
      end
    end else begin
      if (cmd.forbid) begin
        forb_r[in_position][in_digit]  <= 1'b1;
        avail_r[in_position][in_digit] <= 1'b0;
      end
      if (cmd.init_fill) begin
        started_r <= 1'b1;
        p_r       <= '0;
        start_r   <= '0;
        d_r       <= '0;
      end
      if (cmd.init_adv) begin
        ap_r <= n;
      end
      if (cmd.ap_dec) begin
        ap_r <= ap_r - CNT_W'(1);
        p_r  <= ap_r - CNT_W'(1);
      end
      if (cmd.load_d) begin
        d_r <= nf;
      end
      if (cmd.set_start) begin
        start_r <= p_idx;
      end
      if (cmd.fill_begin) begin
        for (int j = 0; j < NPOS; j++) begin
          tried_r[j] <= (j == 0) ? d_first : '0;
        end
        arr_r[p_idx] <= d_first;
        d_r          <= d_first;
      end
      if (cmd.place) begin
        tried_r[k]   <= d_r;
        arr_r[p_idx] <= d_r;
      end
      if (cmd.back) begin
        tried_r[k] <= '0;
        p_r        <= p_r - CNT_W'(1);
      end
      if (cmd.p_inc) begin
        p_r <= p_r + CNT_W'(1);
      end
      // plain availability: same digit at this and every later position below n, unless forbidden there
      if (cmd.mark) begin
        for (int j = 0; j < NPOS; j++) begin
          if ((POS_W'(j) >= p_idx) && (CNT_W'(j) < n) && !forb_r[j][mk_dig]) begin
            avail_r[j][mk_dig] <= cmd.mark_val;
          end
        end
      end
      if (cmd.walk_apply && !forb_r[walk_i_r][walk_nx_r]) begin
        linkav_r[walk_i_r][walk_nx_r] <= walk_val_r;
      end
    end
  end

  // link chain walk, one position per visit
  always_ff @(posedge clk) begin
    if (cmd.mark) begin
      walk_i_r   <= p_idx;
      walk_nx_r  <= mk_dig;
      walk_val_r <= cmd.mark_val;
    end else if (cmd.walk_step) begin
      walk_i_r  <= walk_i_r + POS_W'(1);
      walk_nx_r <= ram_rdata + DIG_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      e_r         <= '0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
      if (cmd.out_found) begin
        e_r <= stat.emit_last ? '0 : e_r + POS_W'(1);
      end else begin
        e_r <= '0;
      end
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_found_r <= cmd.out_found;
      out_slot_r  <= cmd.out_found ? e_r : '0;
      out_digit_r <= cmd.out_found ? arr_r[e_r] : '0;
      out_last_r  <= cmd.out_found ? stat.emit_last : 1'b1;
    end
  end

  assign stat.started      = started_r;
  assign stat.links_en     = links_r;
  assign stat.ap_zero      = (ap_r == '0);
  assign stat.d_zero       = (d_r == '0);
  assign stat.d_first_zero = (d_first == '0);
  assign stat.p_at_n       = (p_r == n);
  assign stat.p_at_start   = (p_idx == start_r);
  assign stat.t_zero       = (tried_r[k] == '0);
  assign stat.walk_last    = ({1'b0, walk_i_r} + CNT_W'(1) == n);
  assign stat.out_free     = !out_valid_r || !out_stall;
  assign stat.emit_last    = ({1'b0, e_r} + CNT_W'(1) == n);

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_slot_index = out_slot_r;
  assign out_slot_digit = out_digit_r;
  assign out_last       = out_last_r;

endmodule

### hdl/cpe_ctrl.sv
// Controller: backtracking search sequencer, mark walk sequencing and word emission.
`timescale 1ns / 1ps
module cpe_ctrl import cpe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic [1:0] in_command,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [11:0] {
    S_IDLE        = 12'b0000_0000_0001,
    S_ADV_CHECK   = 12'b0000_0000_0010,
    S_ADV_FREE    = 12'b0000_0000_0100,
    S_ADV_TRY     = 12'b0000_0000_1000,
    S_FILL_BEGIN  = 12'b0000_0001_0000,
    S_PLACE       = 12'b0000_0010_0000,
    S_FILL_LOOP   = 12'b0000_0100_0000,
    S_FILL_DECIDE = 12'b0000_1000_0000,
    S_WALK_APPLY  = 12'b0001_0000_0000,
    S_WALK_READ   = 12'b0010_0000_0000,
    S_EMIT        = 12'b0100_0000_0000,
    S_FAIL        = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic   adv_mode_r, adv_mode_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    ret_nxt      = ret_r;
    adv_mode_nxt = adv_mode_r;
    cmd          = '0;
    cmd.nf_src   = NF_ARR;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (cmd_t'(in_command))
            CMD_FORBID: cmd.forbid  = 1'b1;
            CMD_LINK:   cmd.link_wr = 1'b1;
            CMD_FIRST: begin
              if (stat.started) begin
                state_nxt = S_FAIL;
              end else begin
                cmd.init_fill = 1'b1;
                adv_mode_nxt  = 1'b0;
                state_nxt     = S_FILL_BEGIN;
              end
            end
            CMD_NEXT: begin
              if (!stat.started) begin
                state_nxt = S_FAIL;
              end else begin
                cmd.init_adv = 1'b1;
                adv_mode_nxt = 1'b1;
                state_nxt    = S_ADV_CHECK;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADV_CHECK: begin
        if (stat.ap_zero) begin
          state_nxt = S_FAIL;
        end else begin
          cmd.ap_dec = 1'b1;
          state_nxt  = S_ADV_FREE;
        end
      end
      S_ADV_FREE: begin
        // search above the held digit, then release it
        cmd.nf_src   = NF_ARR;
        cmd.load_d   = 1'b1;
        cmd.mark     = 1'b1;
        cmd.mark_val = 1'b1;
        ret_nxt      = S_ADV_TRY;
        state_nxt    = stat.links_en ? S_WALK_APPLY : S_ADV_TRY;
      end
      S_ADV_TRY: begin
        if (stat.d_zero) begin
          state_nxt = S_ADV_CHECK;
        end else begin
          cmd.set_start = 1'b1;
          state_nxt     = S_FILL_BEGIN;
        end
      end
      S_FILL_BEGIN: begin
        cmd.nf_src = NF_ZERO;
        if (stat.d_first_zero) begin
          state_nxt = adv_mode_r ? S_ADV_CHECK : S_FAIL;
        end else begin
          cmd.fill_begin = 1'b1;
          state_nxt      = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.mark  = 1'b1;
        cmd.p_inc = 1'b1;
        ret_nxt   = S_FILL_LOOP;
        state_nxt = stat.links_en ? S_WALK_APPLY : S_FILL_LOOP;
      end
      S_FILL_LOOP: begin
        if (stat.p_at_n) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.nf_src = NF_TRIED;
          cmd.load_d = 1'b1;
          if (!stat.t_zero) begin
            cmd.mark     = 1'b1;
            cmd.mark_val = 1'b1;
            ret_nxt      = S_FILL_DECIDE;
            state_nxt    = stat.links_en ? S_WALK_APPLY : S_FILL_DECIDE;
          end else begin
            state_nxt = S_FILL_DECIDE;
          end
        end
      end
      S_FILL_DECIDE: begin
        if (stat.d_zero) begin
          if (stat.p_at_start) begin
            state_nxt = adv_mode_r ? S_ADV_CHECK : S_FAIL;
          end else begin
            cmd.back  = 1'b1;
            state_nxt = S_FILL_LOOP;
          end
        end else begin
          cmd.place = 1'b1;
          state_nxt = S_PLACE;
        end
      end
      S_WALK_APPLY: begin
        cmd.walk_apply = 1'b1;
        state_nxt      = stat.walk_last ? ret_r : S_WALK_READ;
      end
      S_WALK_READ: begin
        cmd.walk_step = 1'b1;
        state_nxt     = S_WALK_APPLY;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_found = 1'b1;
          if (stat.emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_FAIL: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ret_r      <= S_IDLE;
      adv_mode_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ret_r      <= ret_nxt;
      adv_mode_r <= adv_mode_nxt;
    end
  end

endmodule

### hdl/constrained_permutation_enumerator.sv
// Top level: backtracking enumerator of digit arrangements with forbid masks and link chains.
`timescale 1ns / 1ps
// Forbid and link-load words are taken in the idle state without stalling. A first-filling or next command
// runs a backtracking search whose length depends on the data: placing a digit passes through
// test, decide and place, releasing a digit and stepping back passes through test and decide, and an
// advance passes through check, free and try for each position it reopens. With the link chain enabled,
// every mark or release from position p also walks the chain to the last position, alternating
// a table update with one link RAM read per step. Each result word is loaded into the output register and
// held there while the output is stalled; a not-found result is one word.
// The input is stalled from acceptance until the last result word is loaded.
module constrained_permutation_enumerator import cpe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [3:0]       cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_command,
  input  logic [POS_W-1:0] in_position,
  input  logic [DIG_W-1:0] in_digit,
  input  logic [DIG_W-1:0] in_link_target,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_found,
  output logic [POS_W-1:0] out_slot_index,
  output logic [DIG_W-1:0] out_slot_digit,
  output logic             out_last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  cpe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .stat       (stat),
    .cmd        (cmd)
  );

  cpe_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_position    (in_position),
    .in_digit       (in_digit),
    .in_link_target (in_link_target),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_found      (out_found),
    .out_slot_index (out_slot_index),
    .out_slot_digit (out_slot_digit),
    .out_last       (out_last)
  );

endmodule

### test/constrained_permutation_enumerator_test.sv
// Testbench: drives commands and settings into the enumerator and checks every result word.
`timescale 1ns / 1ps
module constrained_permutation_enumerator_test import cpe_pkg::*; ();

  localparam int QUIET_LIMIT = 150000;

  typedef struct {
    bit       found;
    bit [2:0] slot;
    bit [3:0] digit;
    bit       last;
  } slot_word_t;

  // Own copy of the enumerator state; predicts the words each command yields.
  class arrangement_board;
    int unsigned npos_reg, range_reg, diag_reg, links_reg;
    bit [3:0]  held[NPOS];
    bit [15:0] avail[NPOS];
    bit [15:0] forb[NPOS];
    bit [15:0] lavail[NPOS];
    bit [3:0]  ltab[LINK_DEPTH];
    bit [3:0]  tried[NPOS];
    bit        started;
    slot_word_t due[$];
    int        errors;

    function new();
      npos_reg = 8; range_reg = 8; diag_reg = 0; links_reg = 0;
      foreach (ltab[i]) ltab[i] = 0;
      errors = 0;
      restart();
    endfunction

    function int n_eff();
      if (npos_reg < 1) return 1;
      if (npos_reg > NPOS) return NPOS;
      return npos_reg;
    endfunction

    function int top_digit();
      return range_reg > 15 ? 15 : range_reg;
    endfunction

    function void set_marks(int pos, int d, int n, bit value, bit chain);
      int i;
      int nx;
      bit [15:0] b;
      nx = d;
      for (i = pos; i < n; i++) begin
        b = 16'(1) << d;
        if (!(forb[i] & b)) avail[i] = value ? (avail[i] | b) : (avail[i] & ~b);
      end
      if (!chain) return;
      for (i = pos; i < n; i++) begin
        b = 16'(1) << nx;
        if (!(forb[i] & b)) lavail[i] = value ? (lavail[i] | b) : (lavail[i] & ~b);
        nx = (int'(ltab[i * NSLOT + (nx + 15) % NSLOT]) + 1) % NSLOT;
      end
    endfunction

    function bit is_free(int i, int d);
      bit [15:0] b;
      b = 16'(1) << d;
      if (!(avail[i] & b)) return 0;
      if (links_reg != 0 && !(lavail[i] & b)) return 0;
      return 1;
    endfunction

    function int next_free(int i, int from);
      int d;
      for (d = from + 1; d <= top_digit(); d++)
        if (is_free(i, d)) return d;
      return 0;
    endfunction

    function bit fill_from(int start, int first, int n);
      int p, k, t, d;
      bit chain;
      chain = links_reg != 0;
      foreach (tried[i]) tried[i] = 0;
      if (first == 0) first = next_free(start, 0);
      if (first == 0) return 0;
      tried[0] = 4'(first);
      held[start] = 4'(first);
      set_marks(start, first, n, 0, chain);
      p = start + 1;
      while (p < n) begin
        k = p - start;
        t = int'(tried[k]);
        if (t != 0) set_marks(p, t, n, 1, chain);
        d = next_free(p, t);
        if (d == 0) begin
          if (p == start) return 0;
          if (t != 0) set_marks(p, t, n, 1, chain);
          tried[k] = 0;
          p--;
          continue;
        end
        tried[k] = 4'(d);
        held[p] = 4'(d);
        set_marks(p, d, n, 0, chain);
        p++;
      end
      return 1;
    endfunction

    function bit advance(int n);
      int p, d;
      p = n;
      while (p > 0) begin
        p--;
        d = next_free(p, int'(held[p]));
        set_marks(p, int'(held[p]), n, 1, links_reg != 0);
        if (d != 0 && fill_from(p, d, n)) return 1;
      end
      return 0;
    endfunction

    function void restart();
      int n;
      n = n_eff();
      for (int i = 0; i < NPOS; i++) begin
        held[i] = 0;
        tried[i] = 0;
        forb[i] = 0;
        avail[i] = 16'hFFFE;
        lavail[i] = 16'hFFFF;
      end
      started = diag_reg != 0;
      if (started)
        for (int i = 0; i < n; i++) begin
          held[i] = 4'(i + 1);
          set_marks(i, i + 1, n, 0, 0);
        end
    endfunction

    function void configure(cfg_idx_t idx, bit [3:0] v);
      case (idx)
        CFG_NPOS:  npos_reg = 32'(v);
        CFG_RANGE: range_reg = 32'(v);
        CFG_DIAG:  diag_reg = 32'(v[0]);
        CFG_LINKS: links_reg = 32'(v[0]);
        default:   npos_reg = npos_reg;
      endcase
      restart();
    endfunction

    function void note_input(cmd_t cmd, bit [2:0] pos, bit [3:0] dig, bit [3:0] tgt);
      int n;
      bit ok;
      slot_word_t w;
      n = n_eff();
      if (cmd == CMD_FORBID) begin
        forb[pos] |= 16'(1) << dig;
        avail[pos] &= ~(16'(1) << dig);
        return;
      end
      if (cmd == CMD_LINK) begin
        ltab[pos * NSLOT + (dig + 15) % NSLOT] = tgt;
        return;
      end
      if (cmd == CMD_FIRST) begin
        if (started) ok = 0;
        else begin
          started = 1;
          ok = fill_from(0, 0, n);
        end
      end else begin
        ok = started ? advance(n) : 0;
      end
      if (!ok) begin
        w = '{found: 0, slot: 0, digit: 0, last: 1};
        due.push_back(w);
        return;
      end
      for (int k = 0; k < n; k++) begin
        w = '{found: 1, slot: 3'(k), digit: held[k], last: (k + 1 == n)};
        due.push_back(w);
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_word(bit found, bit [2:0] slot, bit [3:0] digit, bit last);
      slot_word_t w;
      if (due.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      w = due.pop_front();
      if (found != w.found) report($sformatf("found %0d, want %0d", found, w.found));
      if (slot != w.slot) report($sformatf("slot %0d, want %0d", slot, w.slot));
      if (digit != w.digit) report($sformatf("digit %0d, want %0d", digit, w.digit));
      if (last != w.last) report($sformatf("last %0d, want %0d", last, w.last));
    endtask
  endclass

  logic             clk = 0;
  logic             rst_n = 0;
  logic             cfg_we = 0;
  logic [1:0]       cfg_index = '0;
  logic [3:0]       cfg_data = '0;
  logic             in_valid = 0;
  logic             in_stall;
  logic [1:0]       in_command = '0;
  logic [POS_W-1:0] in_position = '0;
  logic [DIG_W-1:0] in_digit = '0;
  logic [DIG_W-1:0] in_link_target = '0;
  logic             out_valid;
  logic             out_stall = 0;
  logic             out_found;
  logic [POS_W-1:0] out_slot_index;
  logic [DIG_W-1:0] out_slot_digit;
  logic             out_last;

  constrained_permutation_enumerator dut (.*);

  arrangement_board board = new();
  int sender_gap_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int quiet = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall)
      board.check_word(out_found, out_slot_index, out_slot_digit, out_last);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet = 0;
    else if (++quiet >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task send(cmd_t cmd, bit [2:0] pos, bit [3:0] dig, bit [3:0] tgt);
    if ($urandom_range(99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < sender_gap_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_position <= pos;
    in_digit <= dig;
    in_link_target <= tgt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(cmd, pos, dig, tgt);
  endtask

  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.due.size() != 0) @(posedge clk);
    // no search is running after the last word; the wait only lets the bench settle
    repeat (40) @(posedge clk);
  endtask

  task set_mode(bit [3:0] n, bit [3:0] rng, bit diag, bit links);
    cfg_idx_t idx;
    bit [3:0] vals[4];
    drain();
    vals = '{n, rng, {3'b0, diag}, {3'b0, links}};
    for (int i = 0; i < 4; i++) begin
      idx = cfg_idx_t'(i);
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_data <= vals[i];
      @(posedge clk);
      board.configure(idx, vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  typedef struct {
    int n, rng, diag, links, items, gap, stall, forbids;
    bit hold, pause;
  } phase_t;

  phase_t phases[8] = '{
    '{0, 15, 0, 0, 14, 0, 0, 4, 0, 0},
    '{2, 3, 1, 0, 18, 79, 0, 2, 0, 0},
    '{3, 6, 0, 1, 20, 0, 79, 3, 0, 0},
    '{15, 15, 1, 0, 14, 24, 24, 2, 0, 0},
    '{4, 7, 0, 1, 20, 0, 0, 2, 1, 0},
    '{8, 8, 0, 0, 14, 24, 24, 1, 0, 0},
    '{1, 0, 0, 0, 5, 0, 0, 2, 0, 0},
    '{4, 8, 1, 1, 16, 79, 0, 2, 0, 1}
  };

  initial begin
    int r, fb_left;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // whole link table first, so no chain ever reads an unwritten entry
    for (int p = 0; p < NPOS; p++)
      for (int d = 0; d < NSLOT; d++)
        send(CMD_LINK, 3'(p), 4'(d), 4'($urandom_range(15)));

    send(CMD_NEXT, 0, 0, 0);
    send(CMD_FIRST, 0, 0, 0);
    send(CMD_FIRST, 0, 0, 0);
    send(CMD_NEXT, 0, 0, 0);
    send(CMD_FORBID, 7, 15, 0);
    send(CMD_FORBID, 0, 0, 0);
    send(CMD_FORBID, 6, 8, 0);
    send(CMD_NEXT, 0, 0, 0);
    send(CMD_NEXT, 0, 0, 0);
    send(CMD_LINK, 7, 15, 15);
    send(CMD_NEXT, 0, 0, 0);
    set_mode(1, 0, 0, 0);
    send(CMD_FIRST, 0, 0, 0);
    send(CMD_NEXT, 0, 0, 0);
    set_mode(2, 3, 0, 0);
    send(CMD_FIRST, 0, 0, 0);
    repeat (7) send(CMD_NEXT, 0, 0, 0);

    foreach (phases[i]) begin
      set_mode(4'(phases[i].n), 4'(phases[i].rng), 1'(phases[i].diag),
               1'(phases[i].links));
      sender_gap_pct = phases[i].gap;
      stall_pct = phases[i].stall;
      fb_left = phases[i].forbids;
      if (phases[i].hold) hold_cycles = 400;
      if (phases[i].links == 0 && phases[i].diag == 0) send(CMD_FIRST, 0, 0, 0);
      for (int k = 0; k < phases[i].items; k++) begin
        if (phases[i].pause && k == phases[i].items / 2) drain();
        r = $urandom_range(99);
        if (r < 12 && fb_left > 0) begin
          fb_left--;
          send(CMD_FORBID, 3'($urandom_range(7)), 4'($urandom_range(15)),
               4'($urandom_range(15)));
        end else if (r >= 12 && r < 22) begin
          send(CMD_LINK, 3'($urandom_range(7)), 4'($urandom_range(15)),
               4'($urandom_range(15)));
        end else if (r >= 22 && r < 30) begin
          send(CMD_FIRST, 3'($urandom_range(7)), 4'($urandom_range(15)),
               4'($urandom_range(15)));
        end else begin
          send(CMD_NEXT, 3'($urandom_range(7)), 4'($urandom_range(15)),
               4'($urandom_range(15)));
        end
      end
    end

    drain();
    if (board.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

### sim.f
hdl/cpe_pkg.sv
hdl/cpe_ram.sv
hdl/cpe_datapath.sv
hdl/cpe_ctrl.sv
hdl/constrained_permutation_enumerator.sv
test/constrained_permutation_enumerator_test.sv
